// ===== hdl/humidity_sensor_frame_decoder_core_assert.svh =====
// Assertion macros shared by the frame decoder modules.
// Each macro expects clk and rst_n in scope.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HSFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsfd: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define HSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsfd: assertion failed");

`endif

// ===== hdl/hsfd_pkg.sv =====
package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within a frame
    localparam logic [2:0] POS_HI0  = 3'd0;
    localparam logic [2:0] POS_LO0  = 3'd1;
    localparam logic [2:0] POS_CRC0 = 3'd2;
    localparam logic [2:0] POS_HI1  = 3'd3;
    localparam logic [2:0] POS_LO1  = 3'd4;
    localparam logic [2:0] POS_CRC1 = 3'd5;

    // frame_mode codes
    localparam logic MODE_MEAS   = 1'b0;
    localparam logic MODE_STATUS = 1'b1;

    localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd31500;
    localparam logic [13:0] HUM_SPAN_CENTI    = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET_CENTI = 16'd4900;

    // Completed frame, handed from the byte front end to the conversion back end
    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic        first_bad;
        logic        second_bad;
        logic        status;
    } frame_rec_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/hsfd_front.sv =====
module hsfd_front
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output logic       rec_valid,
    input  logic       rec_ready,
    output frame_rec_t rec_data
);

`include "humidity_sensor_frame_decoder_core_assert.svh"

    logic        mode_reg;
    logic [2:0]  idx_reg,  idx_next;
    logic [7:0]  crc_reg,  crc_next;
    logic [7:0]  hi_reg,   hi_next;
    logic [15:0] w0_reg,   w0_next;
    logic [15:0] w1_reg,   w1_next;
    logic        err0_reg, err0_next;

    logic       fire;
    logic [2:0] pos;
    logic       crc_mismatch;

    assign in_ready     = rec_ready;
    assign fire         = in_valid && in_ready;
    assign crc_mismatch = (rx_byte != crc_reg);

    always_comb
    begin
        pos = frame_start ? POS_HI0 : idx_reg;
        if (mode_reg == MODE_STATUS && pos >= POS_HI1)
            pos = POS_HI0;
        if (pos > POS_CRC1)
            pos = POS_HI0;
    end

    always_comb
    begin
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        hi_next   = hi_reg;
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        err0_next = err0_reg;
        rec_valid = 1'b0;
        rec_data  = '0;
        if (fire)
        begin
            idx_next = pos + 3'd1;
            unique case (pos)
                POS_LO0:
                begin
                    crc_next = crc8_update(crc_reg, rx_byte);
                    w0_next  = {hi_reg, rx_byte};
                end
                POS_LO1:
                begin
                    crc_next = crc8_update(crc_reg, rx_byte);
                    w1_next  = {hi_reg, rx_byte};
                end
                POS_CRC0:
                begin
                    err0_next = crc_mismatch;
                    if (mode_reg == MODE_STATUS)
                    begin
                        rec_valid           = 1'b1;
                        rec_data.first_word = w0_reg;
                        rec_data.first_bad  = crc_mismatch;
                        rec_data.status     = 1'b1;
                        idx_next            = POS_HI0;
                    end
                end
                POS_CRC1:
                begin
                    rec_valid            = 1'b1;
                    rec_data.first_word  = w0_reg;
                    rec_data.second_word = w1_reg;
                    rec_data.first_bad   = err0_reg;
                    rec_data.second_bad  = crc_mismatch;
                    rec_data.status      = 1'b0;
                    idx_next             = POS_HI0;
                end
                default:
                begin
                    // high byte of either word: CRC restarts
                    crc_next = crc8_update(CRC_INIT, rx_byte);
                    hi_next  = rx_byte;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MEAS;
            idx_reg  <= POS_HI0;
            crc_reg  <= CRC_INIT;
            hi_reg   <= '0;
            w0_reg   <= '0;
            w1_reg   <= '0;
            err0_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
            hi_reg   <= hi_next;
            w0_reg   <= w0_next;
            w1_reg   <= w1_next;
            err0_reg <= err0_next;
        end
    end

    // a finished frame always rewinds the byte count
    `HSFD_ASSERT_NEXT(a_push_rewinds, rec_valid && rec_ready, idx_reg == POS_HI0)
    `HSFD_ASSERT_SAME(a_status_short, rec_valid && rec_data.status, rec_data.second_word == '0)

endmodule

// ===== hdl/hsfd_queue.sv =====
module hsfd_queue
    import hsfd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  frame_rec_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output frame_rec_t pop_data
);

`include "humidity_sensor_frame_decoder_core_assert.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `HSFD_ASSERT_NEXT(a_fill_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `HSFD_ASSERT_NEXT(a_drain_shrinks, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== hdl/hsfd_back.sv =====
module hsfd_back
    import hsfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    output logic               rec_ready,
    input  frame_rec_t         rec_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        first_word,
    output logic [15:0]        second_word,
    output logic               first_crc_bad,
    output logic               second_crc_bad,
    output logic signed [15:0] temp_centi_f,
    output logic [13:0]        humidity_centi_pct
);

`include "humidity_sensor_frame_decoder_core_assert.svh"

    // floor(n / 65535) for n below 2^31
    function automatic logic [15:0] div_full(input logic [31:0] n);
        logic [31:0] s;
        s = n + {16'd0, n[31:16]} + 32'd1;
        return s[31:16];
    endfunction

    logic        s1_valid_reg;
    frame_rec_t  s1_rec_reg;
    logic [30:0] temp_prod_reg;
    logic [29:0] hum_prod_reg;

    logic        out_valid_reg;
    logic [15:0] first_word_reg, second_word_reg;
    logic        first_bad_reg, second_bad_reg;
    logic [15:0] temp_reg, temp_next;
    logic [13:0] hum_reg,  hum_next;

    logic        out_adv, s1_adv;
    logic [15:0] temp_q, hum_q;

    assign out_adv   = !out_valid_reg || out_ready;
    assign s1_adv    = !s1_valid_reg || out_adv;
    assign rec_ready = s1_adv;

    assign temp_q = div_full({1'b0, temp_prod_reg});
    assign hum_q  = div_full({2'b0, hum_prod_reg});

    always_comb
    begin
        if (s1_rec_reg.status)
        begin
            temp_next = '0;
            hum_next  = '0;
        end
        else
        begin
            temp_next = temp_q - TEMP_OFFSET_CENTI;
            hum_next  = hum_q[13:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= rec_valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // product stage
    always_ff @(posedge clk)
    begin
        if (s1_adv && rec_valid)
        begin
            s1_rec_reg    <= rec_data;
            temp_prod_reg <= 31'(rec_data.first_word) * 31'(TEMP_SPAN_CENTI);
            hum_prod_reg  <= 30'(rec_data.second_word) * 30'(HUM_SPAN_CENTI);
        end
    end

    // scaling and output register
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            first_word_reg  <= s1_rec_reg.first_word;
            second_word_reg <= s1_rec_reg.second_word;
            first_bad_reg   <= s1_rec_reg.first_bad;
            second_bad_reg  <= s1_rec_reg.second_bad;
            temp_reg        <= temp_next;
            hum_reg         <= hum_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign first_word         = first_word_reg;
    assign second_word        = second_word_reg;
    assign first_crc_bad      = first_bad_reg;
    assign second_crc_bad     = second_bad_reg;
    assign temp_centi_f       = signed'(temp_reg);
    assign humidity_centi_pct = hum_reg;

    `HSFD_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !out_adv,
                      s1_valid_reg && $stable(hum_prod_reg))

endmodule

// ===== hdl/humidity_sensor_frame_decoder_core.sv =====
// Humidity sensor frame decoder.
// Input channel (in_valid/in_ready): one frame byte per transfer, rx_byte in bus
// order, frame_start marking byte 0 of a frame. Each 16-bit word is followed by a
// CRC-8 byte (poly 0x31, init 0xFF) that is checked.
// Output channel (out_valid/out_ready): one transfer per completed frame, with
// the raw words, CRC error flags, temperature in 0.01 F and humidity in 0.01 %.
// cfg_wr_en/cfg_wr_data write frame_mode (0: six-byte measurement frame,
// 1: three-byte status frame); write it only while the block is idle.
// Throughput: one byte per cycle while in_ready is high. The byte front end
// updates the CRC on each byte and pushes finished frames into a QUEUE_DEPTH
// entry queue. Each frame is registered in the queue, even an empty one, then
// in the multiplier stage and in the output register that drives out_valid.
// A receiver stall fills the back end and then the queue; in_ready drops only
// when the queue is full. Reset clears the byte count, sets the CRC to 0xFF,
// selects measurement mode and empties the queue and output stages.
module humidity_sensor_frame_decoder_core
    import hsfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        first_word,
    output logic [15:0]        second_word,
    output logic               first_crc_bad,
    output logic               second_crc_bad,
    output logic signed [15:0] temp_centi_f,
    output logic [13:0]        humidity_centi_pct
);

    logic       push_valid, push_ready;
    frame_rec_t push_data;
    logic       pop_valid, pop_ready;
    frame_rec_t pop_data;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .rec_valid   (push_valid),
        .rec_ready   (push_ready),
        .rec_data    (push_data)
    );

    hsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hsfd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .rec_valid          (pop_valid),
        .rec_ready          (pop_ready),
        .rec_data           (pop_data),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .first_word         (first_word),
        .second_word        (second_word),
        .first_crc_bad      (first_crc_bad),
        .second_crc_bad     (second_crc_bad),
        .temp_centi_f       (temp_centi_f),
        .humidity_centi_pct (humidity_centi_pct)
    );

endmodule
